[rtl/tkt_pkg.sv]
`default_nettype none

package tkt_pkg;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic KIND_HIGH = 1'b0;
  localparam logic KIND_LOW  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [7:0]  temperature;
    logic        [7:0]  timestamp;
  } reading_t;

  typedef struct packed {
    logic               list_kind;
    logic        [2:0]  rank;
    logic signed [7:0]  temp_out;
    logic        [7:0]  time_out;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [7:0]  temp;
    logic        [7:0]  ts;
  } entry_t;

  typedef struct packed {
    logic add_en;
    logic occupied;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/top_k_high_low_tracker_unit.sv]
// Top-k high/low temperature tracker.
//
// Input channel (reading_valid / reading_ready / reading): one item is a command
// with a temperature and a timestamp. An add item is taken in every cycle; it
// enters a row of TOP_COUNT cells per list, each comparing the new reading with
// its own entry and shifting toward the tail, so adds run at one item per
// cycle with no result.
// A report item copies both rows into drain rows and clears the lists in the
// same cycle; adds may follow at once. Results start in the cycle after the
// report is taken: the kept highest in descending order, then the kept lowest
// in ascending order, 2 * count items at one per cycle while result_ready is
// high, last set on the final one. A report with no stored readings gives none.
// Output channel (result_valid / result_ready / result): the drain rows hold the
// results, so a stalled receiver only holds them; adds go on, but a new report
// waits (reading_ready low for it) until the previous report has fully drained.
// Reset (rst, synchronous) empties both lists and drops any report in progress.
`default_nettype none

module top_k_high_low_tracker_unit
  import tkt_pkg::*;
#(
  parameter int TOP_COUNT = 5
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     reading_valid,
  output logic          reading_ready,
  input  wire reading_t reading,
  output logic          result_valid,
  input  wire logic     result_ready,
  output result_t       result
);

  localparam int CW = $clog2(TOP_COUNT + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] snap_count;
  logic          take;
  logic          add_en;
  logic          report_en;
  entry_t        new_entry;

  entry_t        hi_entry [TOP_COUNT];
  entry_t        lo_entry [TOP_COUNT];
  logic          hi_hit   [TOP_COUNT];
  logic          lo_hit   [TOP_COUNT];
  cell_ctl_t     ctl      [TOP_COUNT];

  entry_t        hi_head;
  entry_t        lo_head;
  logic [CW-1:0] hi_rem;
  logic [CW-1:0] lo_rem;
  logic          pop_hi;
  logic          pop_lo;
  logic          report_load;

  assign reading_ready = (reading.cmd == CMD_ADD) || (lo_rem == '0);
  assign take          = reading_valid && reading_ready;
  assign add_en        = take && (reading.cmd == CMD_ADD);
  assign report_en     = take && (reading.cmd == CMD_REPORT);
  assign report_load   = report_en && (count != '0);
  assign new_entry     = '{temp: reading.temperature, ts: reading.timestamp};

  always_comb begin
    count_next = count;
    if (report_en) begin
      count_next = '0;
    end else if (add_en && count != CW'(TOP_COUNT)) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      snap_count <= count;
    end
  end

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    assign ctl[i] = '{add_en: add_en, occupied: (CW'(i) < count)};

    if (i == 0) begin : g_first
      tkt_cell #(.HIGH(1'b1)) u_hi (
        .clk       (clk),
        .ctl       (ctl[i]),
        .new_entry (new_entry),
        .prev_hit  (1'b0),
        .prev_entry(new_entry),
        .entry     (hi_entry[i]),
        .hit       (hi_hit[i])
      );
      tkt_cell #(.HIGH(1'b0)) u_lo (
        .clk       (clk),
        .ctl       (ctl[i]),
        .new_entry (new_entry),
        .prev_hit  (1'b0),
        .prev_entry(new_entry),
        .entry     (lo_entry[i]),
        .hit       (lo_hit[i])
      );
    end else begin : g_rest
      tkt_cell #(.HIGH(1'b1)) u_hi (
        .clk       (clk),
        .ctl       (ctl[i]),
        .new_entry (new_entry),
        .prev_hit  (hi_hit[i-1]),
        .prev_entry(hi_entry[i-1]),
        .entry     (hi_entry[i]),
        .hit       (hi_hit[i])
      );
      tkt_cell #(.HIGH(1'b0)) u_lo (
        .clk       (clk),
        .ctl       (ctl[i]),
        .new_entry (new_entry),
        .prev_hit  (lo_hit[i-1]),
        .prev_entry(lo_entry[i-1]),
        .entry     (lo_entry[i]),
        .hit       (lo_hit[i])
      );
    end
  end

  // high list drains first, then the low list
  assign result_valid = (lo_rem != '0);
  assign pop_hi       = result_valid && result_ready && (hi_rem != '0);
  assign pop_lo       = result_valid && result_ready && (hi_rem == '0);

  tkt_drain #(.DEPTH(TOP_COUNT), .CW(CW)) u_drain_hi (
    .clk         (clk),
    .rst         (rst),
    .load        (report_load),
    .load_count  (count),
    .load_entries(hi_entry),
    .pop         (pop_hi),
    .head        (hi_head),
    .remaining   (hi_rem)
  );

  tkt_drain #(.DEPTH(TOP_COUNT), .CW(CW)) u_drain_lo (
    .clk         (clk),
    .rst         (rst),
    .load        (report_load),
    .load_count  (count),
    .load_entries(lo_entry),
    .pop         (pop_lo),
    .head        (lo_head),
    .remaining   (lo_rem)
  );

  always_comb begin
    if (hi_rem != '0) begin
      result.list_kind = KIND_HIGH;
      result.rank      = 3'(snap_count - hi_rem);
      result.temp_out  = hi_head.temp;
      result.time_out  = hi_head.ts;
      result.last      = 1'b0;
    end else begin
      result.list_kind = KIND_LOW;
      result.rank      = 3'(snap_count - lo_rem);
      result.temp_out  = lo_head.temp;
      result.time_out  = lo_head.ts;
      result.last      = (lo_rem == CW'(1));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TOP_COUNT))
    else $error("entry count above list size");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    report_en |=> (count == '0))
    else $error("lists not cleared after report");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !report_en)
    else $error("report taken while previous report drains");

  a_drain_balance: assert property (@(posedge clk) disable iff (rst)
    hi_rem <= lo_rem)
    else $error("high drain longer than low drain");

  a_heads_ordered: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> ($signed(hi_entry[0].temp) >= $signed(lo_entry[0].temp)))
    else $error("highest entry below lowest entry");

endmodule

`default_nettype wire

[rtl/tkt_cell.sv]
`default_nettype none

module tkt_cell
  import tkt_pkg::*;
#(
  parameter bit HIGH = 1'b1
) (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    new_entry,
  input  wire logic      prev_hit,
  input  wire entry_t    prev_entry,
  output entry_t         entry,
  output logic           hit
);

  logic beats;

  // strict compare keeps equal temperatures in arrival order
  always_comb begin
    if (HIGH) begin
      beats = $signed(new_entry.temp) > $signed(entry.temp);
    end else begin
      beats = $signed(new_entry.temp) < $signed(entry.temp);
    end
    hit = !ctl.occupied || beats;
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en && hit) begin
      entry <= prev_hit ? prev_entry : new_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/tkt_drain.sv]
`default_nettype none

module tkt_drain
  import tkt_pkg::*;
#(
  parameter int DEPTH = 5,
  parameter int CW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic [CW-1:0] load_count,
  input  wire entry_t        load_entries [DEPTH],
  input  wire logic          pop,
  output entry_t             head,
  output logic [CW-1:0]      remaining
);

  entry_t row [DEPTH];

  assign head = row[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= load_count;
    end else if (pop) begin
      remaining <= remaining - CW'(1);
    end
  end

  // each stage hands its entry one step toward the head on every pop
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (load) begin
        row[i] <= load_entries[i];
      end else if (pop && i < DEPTH - 1) begin
        row[i] <= row[i + 1];
      end
    end
  end

endmodule

`default_nettype wire
